>>> rtl/mlfs_pkg.sv
package mlfs_pkg;

    // Command codes carried by an input word.
    localparam logic [2:0] CMD_SET    = 3'd0;
    localparam logic [2:0] CMD_READ   = 3'd1;
    localparam logic [2:0] CMD_INVERT = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_PULL   = 3'd4;

    // Color codes for the set command.
    localparam logic [1:0] COLOR_BLACK       = 2'd0;
    localparam logic [1:0] COLOR_WHITE       = 2'd1;
    localparam logic [1:0] COLOR_TRANSPARENT = 2'd2;
    localparam logic [1:0] COLOR_UNKNOWN     = 2'd3;

    // Status codes of a result word.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RANGE     = 2'd1;
    localparam logic [1:0] STATUS_BAD_COLOR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MIRROR_X = 2'd0;
    localparam logic [1:0] CFG_MIRROR_Y = 2'd1;
    localparam logic [1:0] CFG_FREEZE   = 2'd2;

    // Scan sequencer widths and page header layout.
    localparam int STEP_W    = 9;
    localparam int PAGE_W    = 4;
    localparam int HDR_STEPS = 3;

    localparam logic [7:0] SCAN_START_COL = 8'h04;
    localparam logic [7:0] NIBBLE_MASK    = 8'h0F;
    localparam logic [7:0] COL_LO_BASE    = 8'h00;
    localparam logic [7:0] COL_HI_BASE    = 8'h10;
    localparam logic [7:0] PAGE_BASE      = 8'hB0;
    localparam logic [7:0] COL_LO_BYTE    = COL_LO_BASE | (SCAN_START_COL & NIBBLE_MASK);
    localparam logic [7:0] COL_HI_BYTE    = COL_HI_BASE | ((SCAN_START_COL >> 4) & NIBBLE_MASK);

    // Control from the command logic to the scan sequencer.
    typedef struct packed {
        logic mark;
        logic pull;
    } scan_ctrl_t;

    // Scan-out byte presented by the sequencer.
    typedef struct packed {
        logic       valid;
        logic       is_data;
        logic [7:0] value;
        logic       done;
    } scan_byte_t;

endpackage

>>> rtl/mlfs_item_if.sv
interface mlfs_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] x;
    logic [6:0] y;
    logic [1:0] color;

    modport source (output valid, output command, output x, output y, output color,
                    input ready);
    modport sink (input valid, input command, input x, input y, input color,
                  output ready);
endinterface

>>> rtl/mlfs_result_if.sv
interface mlfs_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       pixel;
    logic       byte_valid;
    logic       byte_is_data;
    logic [7:0] byte_value;
    logic       frame_done;

    modport source (output valid, output status, output pixel, output byte_valid,
                    output byte_is_data, output byte_value, output frame_done,
                    input ready);
    modport sink (input valid, input status, input pixel, input byte_valid,
                  input byte_is_data, input byte_value, input frame_done,
                  output ready);
endinterface

>>> rtl/mlfs_cfg_if.sv
interface mlfs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic       data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/mono_lcd_framebuffer_scanout.sv
// Monochrome page-layout frame store with serial scan-out.
//
// Channels: item (sink) takes one command word: set, read or invert a
// pixel, clear the store, or pull the next scan-out byte. result (source)
// returns exactly one word per item with status, pixel value and the
// scan-out byte fields. cfg takes register writes (mirror_x, mirror_y,
// freeze) at any time it is valid; ready is always high.
// Each item has a read step, which reads the store byte, and a
// write-back step, which modifies it, writes it back and loads the
// result register; a new item is accepted only after the last one is
// written back, as set by the read-modify-write on the frame store.
// After reset, and after every clear command, a clearing pass writes
// zero to all WIDTH*(HEIGHT/8) store bytes, one byte a cycle, during
// which no item is accepted; the clear command's result is delivered
// at once. When the receiver stalls, the finished word waits in the
// output register and the next item is accepted but holds in its
// write-back cycle until the output register frees up.
module mono_lcd_framebuffer_scanout #(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64
) (
    input logic          clk,
    input logic          rst_n,
    mlfs_item_if.sink    item,
    mlfs_result_if.source result,
    mlfs_cfg_if.sink     cfg
);

    import mlfs_pkg::*;

    localparam int PAGES       = HEIGHT / 8;
    localparam int STORE_BYTES = WIDTH * PAGES;
    localparam int AW          = $clog2(STORE_BYTES);

    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);
    localparam logic [AW:0]   STORE_END = (AW + 1)'(STORE_BYTES);
    localparam logic [AW:0]   PAGES_W   = (AW + 1)'(PAGES);
    localparam logic [7:0]    X_MAX     = 8'(WIDTH - 1);
    localparam logic [6:0]    Y_MAX     = 7'(HEIGHT - 1);
    localparam logic [8:0]    X_LIM     = 9'(WIDTH);
    localparam logic [7:0]    Y_LIM     = 8'(HEIGHT);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    logic       mirror_x_reg;
    logic       mirror_y_reg;
    logic       freeze_reg;

    logic [2:0]    cmd_reg;
    logic [1:0]    color_reg;
    logic          oor_reg;
    logic [2:0]    bit_reg;
    logic [AW-1:0] addr_reg;

    logic       out_valid_reg;
    logic [1:0] status_reg;
    logic       pixel_reg;
    logic       byte_valid_reg;
    logic       byte_is_data_reg;
    logic [7:0] byte_value_reg;
    logic       frame_done_reg;

    logic          accept;
    logic          commit;
    logic [7:0]    xm;
    logic [6:0]    ym;
    logic [AW:0]   pix_sum;
    logic [AW-1:0] pix_addr;
    logic          oor;
    logic [AW-1:0] scan_addr;
    logic [7:0]    rdata;
    logic [7:0]    mask;

    logic [1:0] exec_status;
    logic       exec_pixel;
    logic       exec_we;
    logic [7:0] exec_wdata;
    logic       exec_mark;
    logic       exec_pull;
    logic       exec_clear;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;

    scan_ctrl_t scan_ctrl;
    scan_byte_t scan_byte;

    // Handshakes.
    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign commit     = (state_reg == ST_EXEC) && (!out_valid_reg || result.ready);
    assign cfg.ready  = 1'b1;

    // Range check on raw coordinates, then mirroring and byte address.
    assign oor      = ({1'b0, item.x} >= X_LIM) || ({1'b0, item.y} >= Y_LIM);
    assign xm       = mirror_x_reg ? (X_MAX - item.x) : item.x;
    assign ym       = mirror_y_reg ? (Y_MAX - item.y) : item.y;
    assign pix_sum  = (AW + 1)'(xm) * PAGES_W + (AW + 1)'(ym[6:3]);
    assign pix_addr = (pix_sum >= STORE_END) ? AW'(pix_sum - STORE_END) : pix_sum[AW-1:0];

    // Read address: the pixel byte, or the next scan data byte for a pull.
    assign mem_raddr = (item.command == CMD_PULL) ? scan_addr : pix_addr;

    // Latch the accepted word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= item.command;
            color_reg <= item.color;
            oor_reg   <= oor;
            bit_reg   <= ym[2:0];
            addr_reg  <= pix_addr;
        end
    end

    assign mask = 8'b1 << bit_reg;

    // Modify step on the byte read back from the store.
    always_comb
    begin
        exec_status = STATUS_OK;
        exec_pixel  = 1'b0;
        exec_we     = 1'b0;
        exec_wdata  = rdata;
        exec_mark   = 1'b0;
        exec_pull   = 1'b0;
        exec_clear  = 1'b0;
        case (cmd_reg)
            CMD_SET:
            begin
                if (oor_reg)
                begin
                    exec_status = STATUS_RANGE;
                end
                else
                begin
                    exec_mark = 1'b1;
                    case (color_reg)
                        COLOR_BLACK:
                        begin
                            exec_we    = 1'b1;
                            exec_wdata = rdata | mask;
                        end
                        COLOR_WHITE:
                        begin
                            exec_we    = 1'b1;
                            exec_wdata = rdata & ~mask;
                        end
                        COLOR_TRANSPARENT: exec_status = STATUS_OK;
                        COLOR_UNKNOWN:     exec_status = STATUS_BAD_COLOR;
                        default:           exec_status = STATUS_OK;
                    endcase
                end
            end
            CMD_READ:
            begin
                if (oor_reg)
                begin
                    exec_status = STATUS_RANGE;
                end
                else
                begin
                    exec_pixel = rdata[bit_reg];
                end
            end
            CMD_INVERT:
            begin
                if (oor_reg)
                begin
                    exec_status = STATUS_RANGE;
                end
                else
                begin
                    exec_mark  = 1'b1;
                    exec_we    = 1'b1;
                    exec_wdata = rdata ^ mask;
                end
            end
            CMD_CLEAR:
            begin
                exec_mark  = 1'b1;
                exec_clear = 1'b1;
            end
            CMD_PULL: exec_pull = 1'b1;
            default:  exec_status = STATUS_OK;
        endcase
    end

    assign scan_ctrl.mark = commit && exec_mark;
    assign scan_ctrl.pull = commit && exec_pull;

    // Store write port: clearing pass or write-back.
    assign mem_we    = (state_reg == ST_CLEAR) || (commit && exec_we);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? 8'h00 : exec_wdata;

    mlfs_store #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    mlfs_scan #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT),
        .AW     (AW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .freeze    (freeze_reg),
        .rdata     (rdata),
        .data_addr (scan_addr),
        .scan_byte (scan_byte)
    );

    // Sequencer: clearing pass, idle, write-back.
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next    = ST_IDLE;
                    clr_addr_next = '0;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next    = exec_clear ? ST_CLEAR : ST_IDLE;
                    clr_addr_next = '0;
                end
            end
            default:
            begin
                state_next    = ST_CLEAR;
                clr_addr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_x_reg <= 1'b0;
            mirror_y_reg <= 1'b0;
            freeze_reg   <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MIRROR_X: mirror_x_reg <= cfg.data;
                CFG_MIRROR_Y: mirror_y_reg <= cfg.data;
                CFG_FREEZE:   freeze_reg   <= cfg.data;
                default:      freeze_reg   <= freeze_reg;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg       <= exec_status;
            pixel_reg        <= exec_pixel;
            byte_valid_reg   <= scan_byte.valid;
            byte_is_data_reg <= scan_byte.is_data;
            byte_value_reg   <= scan_byte.value;
            frame_done_reg   <= scan_byte.done;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = status_reg;
    assign result.pixel        = pixel_reg;
    assign result.byte_valid   = byte_valid_reg;
    assign result.byte_is_data = byte_is_data_reg;
    assign result.byte_value   = byte_value_reg;
    assign result.frame_done   = frame_done_reg;

endmodule

>>> rtl/mlfs_store.sv
module mlfs_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mlfs_scan.sv
module mlfs_scan #(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64,
    parameter int AW     = $clog2(WIDTH * (HEIGHT / 8))
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mlfs_pkg::scan_ctrl_t ctrl,
    input  logic                 freeze,
    input  logic [7:0]           rdata,
    output logic [AW-1:0]        data_addr,
    output mlfs_pkg::scan_byte_t scan_byte
);

    import mlfs_pkg::*;

    localparam int PAGES = HEIGHT / 8;
    localparam logic [STEP_W-1:0] STEP_END  = STEP_W'(HDR_STEPS + WIDTH);
    localparam logic [STEP_W-1:0] HDR_LEN   = STEP_W'(HDR_STEPS);
    localparam logic [PAGE_W:0]   PAGE_END  = (PAGE_W + 1)'(PAGES);
    localparam logic [AW-1:0]     PAGES_A   = AW'(PAGES);

    logic              pending_reg;
    logic              active_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [STEP_W-1:0] step_reg;

    logic              start;
    logic              run;
    logic [STEP_W-1:0] step_inc;
    logic [PAGE_W:0]   page_inc;
    logic              wrap;
    logic              last;
    logic [7:0]        col;
    logic [7:0]        hdr_value;

    // A pull with an update pending starts a frame unless frozen.
    assign start = ctrl.pull && !active_reg && pending_reg;
    assign run   = active_reg || (start && !freeze);

    assign step_inc = step_reg + 1'b1;
    assign page_inc = {1'b0, page_reg} + 1'b1;
    assign wrap     = step_inc >= STEP_END;
    assign last     = page_inc >= PAGE_END;

    // Store address of the data byte at the current scan position.
    assign col       = 8'(step_reg - HDR_LEN);
    assign data_addr = AW'(col) * PAGES_A + AW'(page_reg);

    // Header bytes of a page.
    always_comb
    begin
        case (step_reg)
            STEP_W'(0): hdr_value = COL_LO_BYTE;
            STEP_W'(1): hdr_value = COL_HI_BYTE;
            default:    hdr_value = PAGE_BASE | ({4'b0, page_reg} & NIBBLE_MASK);
        endcase
    end

    // Byte presented for this pull.
    always_comb
    begin
        scan_byte.valid   = ctrl.pull && run;
        scan_byte.is_data = scan_byte.valid && (step_reg >= HDR_LEN);
        scan_byte.done    = scan_byte.valid && wrap && last;
        if (!scan_byte.valid)
        begin
            scan_byte.value = 8'h00;
        end
        else if (step_reg >= HDR_LEN)
        begin
            scan_byte.value = rdata;
        end
        else
        begin
            scan_byte.value = hdr_value;
        end
    end

    // Scan position and pending flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b1;
            active_reg  <= 1'b0;
            page_reg    <= '0;
            step_reg    <= '0;
        end
        else
        begin
            if (ctrl.mark)
            begin
                pending_reg <= 1'b1;
            end
            else if (start)
            begin
                pending_reg <= 1'b0;
            end

            if (ctrl.pull && run)
            begin
                if (wrap)
                begin
                    step_reg <= '0;
                    if (last)
                    begin
                        page_reg   <= '0;
                        active_reg <= 1'b0;
                    end
                    else
                    begin
                        page_reg   <= page_inc[PAGE_W-1:0];
                        active_reg <= 1'b1;
                    end
                end
                else
                begin
                    step_reg   <= step_inc;
                    active_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> sim/tb_mono_lcd_framebuffer_scanout.sv
`timescale 1ns / 100ps

module tb_mono_lcd_framebuffer_scanout;
    import mlfs_pkg::*;

    localparam int LCD_W       = 128;
    localparam int LCD_H       = 64;
    localparam int PAGES       = LCD_H / 8;
    localparam int STORE_BYTES = LCD_W * PAGES;
    localparam int CLK_HALF    = 2;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_LIMIT = 20000;
    localparam int PRINT_LIMIT = 40;

    // Command values outside the defined set; the block must ignore them.
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] x;
        logic [6:0] y;
        logic [1:0] color;
    } lcd_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       pixel;
        logic       byte_valid;
        logic       byte_is_data;
        logic [7:0] byte_value;
        logic       frame_done;
    } lcd_result_t;

    logic clk;
    logic rst_n;

    mlfs_item_if   item_bus ();
    mlfs_result_if result_bus ();
    mlfs_cfg_if    cfg_bus ();

    mono_lcd_framebuffer_scanout #(
        .WIDTH  (LCD_W),
        .HEIGHT (LCD_H)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // Shadow copy of the frame store, the scan sequencer and the registers.
    logic [7:0]  lcd_bytes [STORE_BYTES];
    logic        refresh_pending;
    logic        scan_running;
    logic [3:0]  scan_page_now;
    int          scan_step_now;
    logic        mir_x;
    logic        mir_y;
    logic        frozen;

    lcd_result_t results_due [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_request;

    always #CLK_HALF clk = ~clk;

    // Returns an idle length: mostly none, mostly short when there is one.
    function automatic int pick_idle(int pct);
        if ($urandom_range(99) >= pct)
        begin
            return 0;
        end
        if ($urandom_range(9) == 0)
        begin
            return $urandom_range(40, 10);
        end
        return $urandom_range(3, 1);
    endfunction

    // Works out the result word for one accepted command word and updates
    // the shadow state the same way the block does.
    function automatic lcd_result_t predict_word(lcd_item_t it);
        lcd_result_t r;
        int unsigned px;
        int unsigned py;
        int unsigned addr;
        logic [7:0]  mask;

        r = '0;
        px = 32'(it.x);
        py = 32'(it.y);
        case (it.command)
            CMD_SET, CMD_READ, CMD_INVERT:
            begin
                // The range check uses the coordinates as given, before mirroring.
                if (px >= LCD_W || py >= LCD_H)
                begin
                    r.status = STATUS_RANGE;
                    return r;
                end
                if (mir_x)
                begin
                    px = LCD_W - 1 - px;
                end
                if (mir_y)
                begin
                    py = LCD_H - 1 - py;
                end
                addr = px * PAGES + py / 8;
                mask = 8'd1 << (py % 8);
                if (it.command == CMD_SET)
                begin
                    if (it.color == COLOR_BLACK)
                    begin
                        lcd_bytes[addr] = lcd_bytes[addr] | mask;
                    end
                    else if (it.color == COLOR_WHITE)
                    begin
                        lcd_bytes[addr] = lcd_bytes[addr] & ~mask;
                    end
                    else if (it.color == COLOR_UNKNOWN)
                    begin
                        r.status = STATUS_BAD_COLOR;
                    end
                    refresh_pending = 1'b1;
                end
                else if (it.command == CMD_READ)
                begin
                    r.pixel = |(lcd_bytes[addr] & mask);
                end
                else
                begin
                    lcd_bytes[addr] = lcd_bytes[addr] ^ mask;
                    refresh_pending = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                foreach (lcd_bytes[i])
                begin
                    lcd_bytes[i] = 8'h00;
                end
                refresh_pending = 1'b1;
            end
            CMD_PULL:
            begin
                // A pending update starts a frame unless frozen, where it is dropped.
                if (!scan_running && refresh_pending)
                begin
                    refresh_pending = 1'b0;
                    if (!frozen)
                    begin
                        scan_running = 1'b1;
                        scan_page_now = '0;
                        scan_step_now = 0;
                    end
                end
                if (scan_running)
                begin
                    r.byte_valid = 1'b1;
                    if (scan_step_now == 0)
                    begin
                        r.byte_value = COL_LO_BYTE;
                    end
                    else if (scan_step_now == 1)
                    begin
                        r.byte_value = COL_HI_BYTE;
                    end
                    else if (scan_step_now == 2)
                    begin
                        r.byte_value = PAGE_BASE | {4'h0, scan_page_now};
                    end
                    else
                    begin
                        r.byte_value =
                            lcd_bytes[(scan_step_now - HDR_STEPS) * PAGES + scan_page_now];
                        r.byte_is_data = 1'b1;
                    end
                    scan_step_now++;
                    if (scan_step_now >= HDR_STEPS + LCD_W)
                    begin
                        scan_step_now = 0;
                        if (scan_page_now == 4'(PAGES - 1))
                        begin
                            scan_page_now = '0;
                            scan_running = 1'b0;
                            r.frame_done = 1'b1;
                        end
                        else
                        begin
                            scan_page_now++;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        mismatches++;
        // Keep the log short when the design is badly broken.
        if (mismatches <= PRINT_LIMIT)
        begin
            $display("ERROR %0t ns: %s got %0d expected %0d", $time, field, got, want);
        end
    endtask

    task automatic check_result_word();
        lcd_result_t want;

        if (results_due.size() == 0)
        begin
            report_mismatch("result word with nothing due", 1, 0);
            return;
        end
        want = results_due.pop_front();
        if (result_bus.status !== want.status)
        begin
            report_mismatch("status", int'(result_bus.status), int'(want.status));
        end
        if (result_bus.pixel !== want.pixel)
        begin
            report_mismatch("pixel", int'(result_bus.pixel), int'(want.pixel));
        end
        if (result_bus.byte_valid !== want.byte_valid)
        begin
            report_mismatch("byte_valid", int'(result_bus.byte_valid),
                            int'(want.byte_valid));
        end
        if (result_bus.byte_is_data !== want.byte_is_data)
        begin
            report_mismatch("byte_is_data", int'(result_bus.byte_is_data),
                            int'(want.byte_is_data));
        end
        if (result_bus.byte_value !== want.byte_value)
        begin
            report_mismatch("byte_value", int'(result_bus.byte_value),
                            int'(want.byte_value));
        end
        if (result_bus.frame_done !== want.frame_done)
        begin
            report_mismatch("frame_done", int'(result_bus.frame_done),
                            int'(want.frame_done));
        end
    endtask

    // Offers one command word and records its expected result once accepted.
    task automatic send_item(logic [2:0] cmd, logic [7:0] px, logic [6:0] py,
                             logic [1:0] col);
        int        gap;
        lcd_item_t it;

        gap = pick_idle(send_idle_pct);
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid   <= 1'b1;
        item_bus.command <= cmd;
        item_bus.x       <= px;
        item_bus.y       <= py;
        item_bus.color   <= col;
        @(posedge clk);
        while (!item_bus.ready)
        begin
            @(posedge clk);
        end
        it.command = cmd;
        it.x = px;
        it.y = py;
        it.color = col;
        results_due.push_back(predict_word(it));
    endtask

    // Stops offering words and waits until every result has come back.
    task automatic wait_idle();
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // Writes all three registers back to back; only called while idle.
    task automatic apply_config(logic mx, logic my, logic fz);
        logic [1:0] idx [3];
        logic       val [3];

        idx[0] = CFG_MIRROR_X;
        idx[1] = CFG_MIRROR_Y;
        idx[2] = CFG_FREEZE;
        val[0] = mx;
        val[1] = my;
        val[2] = fz;
        cfg_bus.valid <= 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cfg_bus.index <= idx[i];
            cfg_bus.data  <= val[i];
            @(posedge clk);
            while (!cfg_bus.ready)
            begin
                @(posedge clk);
            end
        end
        cfg_bus.valid <= 1'b0;
        mir_x = mx;
        mir_y = my;
        frozen = fz;
    endtask

    // Mostly scan pulls and in-range pixel writes, with some noise words.
    task automatic send_random_item();
        int         pick;
        logic [7:0] px;
        logic [6:0] py;
        logic [1:0] col;

        pick = $urandom_range(99);
        if ($urandom_range(9) == 0)
        begin
            px = 8'($urandom_range(255));
            py = 7'($urandom_range(127));
        end
        else
        begin
            px = 8'($urandom_range(LCD_W - 1));
            py = 7'($urandom_range(LCD_H - 1));
        end
        col = ($urandom_range(7) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1));
        if (pick < 78)
        begin
            send_item(CMD_PULL, px, py, col);
        end
        else if (pick < 88)
        begin
            send_item(CMD_SET, px, py, col);
        end
        else if (pick < 93)
        begin
            send_item(CMD_READ, px, py, 2'($urandom_range(3)));
        end
        else if (pick < 97)
        begin
            send_item(CMD_INVERT, px, py, 2'($urandom_range(3)));
        end
        else if (pick < 98)
        begin
            send_item(CMD_CLEAR, px, py, col);
        end
        else
        begin
            send_item(3'($urandom_range(7)), 8'($urandom_range(255)),
                      7'($urandom_range(127)), 2'($urandom_range(3)));
        end
    endtask

    task automatic run_traffic_phase(int count, logic mx, logic my, logic fz,
                                     int send_pct, int recv_pct);
        wait_idle();
        apply_config(mx, my, fz);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
        begin
            send_random_item();
        end
    endtask

    // Frozen: the first pull drops the pending update, the second finds nothing.
    task automatic test_frozen_pull();
        apply_config(1'b0, 1'b0, 1'b1);
        send_item(CMD_PULL, 8'd0, 7'd0, COLOR_BLACK);
        send_item(CMD_PULL, 8'd0, 7'd0, COLOR_BLACK);
        wait_idle();
        apply_config(1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_pixel_access();
        send_item(CMD_SET, 8'd0, 7'd0, COLOR_BLACK);
        send_item(CMD_SET, 8'd127, 7'd63, COLOR_BLACK);
        send_item(CMD_READ, 8'd0, 7'd0, COLOR_BLACK);
        send_item(CMD_READ, 8'd127, 7'd63, COLOR_WHITE);
        send_item(CMD_SET, 8'd128, 7'd0, COLOR_BLACK);
        send_item(CMD_SET, 8'd0, 7'd64, COLOR_BLACK);
        send_item(CMD_READ, 8'd255, 7'd127, COLOR_UNKNOWN);
        send_item(CMD_INVERT, 8'd5, 7'd9, COLOR_WHITE);
        send_item(CMD_READ, 8'd5, 7'd9, COLOR_BLACK);
        send_item(CMD_INVERT, 8'd5, 7'd9, COLOR_UNKNOWN);
        send_item(CMD_SET, 8'd3, 7'd3, COLOR_TRANSPARENT);
        send_item(CMD_SET, 8'd3, 7'd3, COLOR_UNKNOWN);
        send_item(CMD_READ, 8'd3, 7'd3, COLOR_UNKNOWN);
        send_item(CMD_SET, 8'd0, 7'd0, COLOR_WHITE);
        send_item(CMD_READ, 8'd0, 7'd0, COLOR_BLACK);
    endtask

    task automatic test_spare_commands();
        send_item(CMD_SPARE_LO, 8'hFF, 7'h7F, COLOR_UNKNOWN);
        send_item(CMD_SPARE_HI, 8'h55, 7'h2A, COLOR_WHITE);
    endtask

    // Starts a frame, clears the store while it runs, then pulls again.
    task automatic test_scan_and_clear();
        send_item(CMD_PULL, 8'd0, 7'd0, COLOR_BLACK);
        send_item(CMD_PULL, 8'd0, 7'd0, COLOR_BLACK);
        send_item(CMD_CLEAR, 8'd0, 7'd0, COLOR_BLACK);
        send_item(CMD_PULL, 8'd0, 7'd0, COLOR_BLACK);
        send_item(CMD_READ, 8'd0, 7'd0, COLOR_BLACK);
    endtask

    // The receiver holds off while words keep coming, so the input stalls.
    task automatic test_backpressure();
        wait_idle();
        send_idle_pct = 0;
        hold_request = 300;
        repeat (16)
        begin
            send_random_item();
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(300, 1'b0, 1'b0, 1'b0, 20, 20);
        run_traffic_phase(300, 1'b1, 1'b0, 1'b0, 0, 0);
        run_traffic_phase(300, 1'b0, 1'b1, 1'b0, 40, 40);
        run_traffic_phase(300, 1'b1, 1'b1, 1'b0, 20, 10);
        run_traffic_phase(300, 1'b0, 1'b0, 1'b0, 10, 30);
        run_traffic_phase(300, 1'b1, 1'b1, 1'b1, 30, 20);
    endtask

    // Result side: check each accepted word, then choose the next ready.
    initial
    begin
        int hold_left;
        int stall_left;

        hold_left = 0;
        stall_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
            begin
                check_result_word();
            end
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                stall_left = pick_idle(recv_idle_pct);
            end
        end
    end

    // Watchdog.
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Main sequence.
    initial
    begin
        int waited;

        clk = 1'b0;
        rst_n = 1'b0;
        mismatches = 0;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        hold_request = 0;
        item_bus.valid   <= 1'b0;
        item_bus.command <= CMD_READ;
        item_bus.x       <= '0;
        item_bus.y       <= '0;
        item_bus.color   <= COLOR_BLACK;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= CFG_MIRROR_X;
        cfg_bus.data     <= 1'b0;
        foreach (lcd_bytes[i])
        begin
            lcd_bytes[i] = 8'h00;
        end
        refresh_pending = 1'b1;
        scan_running = 1'b0;
        scan_page_now = '0;
        scan_step_now = 0;
        mir_x = 1'b0;
        mir_y = 1'b0;
        frozen = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frozen_pull();
        test_pixel_access();
        test_spare_commands();
        test_scan_and_clear();
        test_backpressure();
        test_random_traffic();

        // Let the last results drain, then let the bench settle before the verdict.
        item_bus.valid <= 1'b0;
        waited = 0;
        while (results_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (results_due.size() != 0)
        begin
            report_mismatch("results never delivered", 0, results_due.size());
        end
        repeat (20) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
